// File: rtl/bsc_pkg.sv
// shared types, constants and arithmetic helpers for the barometric compensation
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int DivSteps = 32;
	localparam logic [31:0] PressOffset = 32'd64000;
	localparam logic [31:0] PressBase = 32'd1048576;
	localparam logic [31:0] PressMul = 32'd3125;
	localparam logic [31:0] ScaleBase = 32'd32768;
	localparam logic [31:0] TempRound = 32'd128;

	localparam logic [1:0] RegTemp = 2'd0;
	localparam logic [1:0] RegPressA = 2'd1;
	localparam logic [1:0] RegPressB = 2'd2;
	localparam logic [1:0] RegPressC = 2'd3;

	// calibration coefficients, sign or zero extended to 32 bits
	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	} coef_t;

	// data that rides alongside the divider
	typedef struct packed {
		logic [18:0] temp;
		logic        zero;
		logic        hi;
	} side_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		asr = $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		mul32 = p[31:0];
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

endpackage

// File: rtl/bsc_front.sv
// fine temperature and pressure terms ahead of the division
`timescale 1ns / 1ps
module bsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [19:0]        adc_t,
	input  logic [19:0]        adc_p,
	input  bsc_pkg::coef_t     coef,
	output logic               out_valid,
	output logic [31:0]        dividend,
	output logic [31:0]        divisor,
	output bsc_pkg::side_t     side
);

	logic [9:0] v_q;
	logic [31:0] x1_s1, d_s1;
	logic [19:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8, ap_s9;
	logic [31:0] m1_s2, dd_s2;
	logic [31:0] a_s3, m3_s3;
	logic [31:0] fine_s4;
	logic [18:0] t_s5, t_s6, t_s7, t_s8, t_s9, t_s10;
	logic [31:0] pa_s5;
	logic [31:0] sq_s6, m5_s6, m2_s6;
	logic [31:0] b1_s7, m3b_s7, m5_s7, m2_s7;
	logic [31:0] b_s8, a2_s8;
	logic [31:0] b_s9, sc_s9;
	logic [31:0] pv_s10, sc_s10;
	logic        z_s10;
	logic [31:0] t5, q6;

	assign t5 = bsc_pkg::asr(bsc_pkg::mul32(fine_s4, 32'd5) + bsc_pkg::TempRound, 8);
	assign q6 = bsc_pkg::asr(pa_s5, 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[8:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= {15'd0, adc_t[19:3]} - {coef.t1[30:0], 1'b0};
			d_s1 <= {16'd0, adc_t[19:4]} - coef.t1;
			ap_s1 <= adc_p;
			m1_s2 <= bsc_pkg::mul32(x1_s1, coef.t2);
			dd_s2 <= bsc_pkg::mul32(d_s1, d_s1);
			ap_s2 <= ap_s1;
			a_s3 <= bsc_pkg::asr(m1_s2, 11);
			m3_s3 <= bsc_pkg::mul32(bsc_pkg::asr(dd_s2, 12), coef.t3);
			ap_s3 <= ap_s2;
			fine_s4 <= a_s3 + bsc_pkg::asr(m3_s3, 14);
			ap_s4 <= ap_s3;
			t_s5 <= t5[18:0];
			pa_s5 <= bsc_pkg::asr(fine_s4, 1) - bsc_pkg::PressOffset;
			ap_s5 <= ap_s4;
			sq_s6 <= bsc_pkg::mul32(q6, q6);
			m5_s6 <= bsc_pkg::mul32(pa_s5, coef.p5);
			m2_s6 <= bsc_pkg::mul32(coef.p2, pa_s5);
			t_s6 <= t_s5;
			ap_s6 <= ap_s5;
			b1_s7 <= bsc_pkg::mul32(bsc_pkg::asr(sq_s6, 11), coef.p6);
			m3b_s7 <= bsc_pkg::mul32(coef.p3, bsc_pkg::asr(sq_s6, 13));
			m5_s7 <= m5_s6;
			m2_s7 <= m2_s6;
			t_s7 <= t_s6;
			ap_s7 <= ap_s6;
			b_s8 <= bsc_pkg::asr(b1_s7 + {m5_s7[30:0], 1'b0}, 2) + {coef.p4[15:0], 16'd0};
			a2_s8 <= bsc_pkg::asr(bsc_pkg::asr(m3b_s7, 3) + bsc_pkg::asr(m2_s7, 1), 18);
			t_s8 <= t_s7;
			ap_s8 <= ap_s7;
			sc_s9 <= bsc_pkg::asr(bsc_pkg::mul32(bsc_pkg::ScaleBase + a2_s8, coef.p1), 15);
			b_s9 <= b_s8;
			t_s9 <= t_s8;
			ap_s9 <= ap_s8;
			pv_s10 <= bsc_pkg::mul32((bsc_pkg::PressBase - {12'd0, ap_s9})
				- bsc_pkg::asr(b_s9, 12), bsc_pkg::PressMul);
			sc_s10 <= sc_s9;
			z_s10 <= (sc_s9 == 32'd0);
			t_s10 <= t_s9;
		end
	end

	assign out_valid = v_q[9];
	assign divisor = sc_s10;
	assign dividend = pv_s10[31] ? pv_s10 : {pv_s10[30:0], 1'b0};
	assign side = '{temp: t_s10, zero: z_s10, hi: pv_s10[31]};

endmodule

// File: rtl/bsc_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module bsc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [31:0]        num,
	input  logic [31:0]        den,
	input  bsc_pkg::side_t     in_side,
	output logic               out_valid,
	output logic [31:0]        quo,
	output bsc_pkg::side_t     out_side
);

	localparam int N = bsc_pkg::DivSteps;

	logic [N-1:0]  v_q;
	logic [31:0]   rem_q [N];
	logic [31:0]   num_q [N];
	logic [31:0]   den_q [N];
	logic [31:0]   quo_q [N];
	bsc_pkg::side_t side_q [N];

	logic [31:0] rem_n [N];
	logic [31:0] num_n [N];
	logic [31:0] quo_n [N];

	always_comb begin
		for (int j = 0; j < N; j++) begin
			logic [32:0] r;
			logic [31:0] rin, nin, qin, dv;
			rin = (j == 0) ? 32'd0 : rem_q[(j == 0) ? 0 : j - 1];
			nin = (j == 0) ? num : num_q[(j == 0) ? 0 : j - 1];
			qin = (j == 0) ? 32'd0 : quo_q[(j == 0) ? 0 : j - 1];
			dv = (j == 0) ? den : den_q[(j == 0) ? 0 : j - 1];
			r = {rin, nin[31]};
			if (r >= {1'b0, dv}) begin
				r = r - {1'b0, dv};
				quo_n[j] = {qin[30:0], 1'b1};
			end else begin
				quo_n[j] = {qin[30:0], 1'b0};
			end
			rem_n[j] = r[31:0];
			num_n[j] = {nin[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < N; j++) begin
				rem_q[j] <= rem_n[j];
				num_q[j] <= num_n[j];
				quo_q[j] <= quo_n[j];
				den_q[j] <= (j == 0) ? den : den_q[(j == 0) ? 0 : j - 1];
				side_q[j] <= (j == 0) ? in_side : side_q[(j == 0) ? 0 : j - 1];
			end
		end
	end

	assign out_valid = v_q[N-1];
	assign quo = quo_q[N-1];
	assign out_side = side_q[N-1];

endmodule

// File: rtl/bsc_post.sv
// pressure correction after the division
`timescale 1ns / 1ps
module bsc_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [31:0]        quo,
	input  bsc_pkg::side_t     in_side,
	input  bsc_pkg::coef_t     coef,
	output logic               out_valid,
	output logic [18:0]        temp,
	output logic [31:0]        press,
	output logic               zero
);

	logic [3:0]  v_q;
	logic [31:0] p_s1, p_s2, p_s3, press_s4;
	logic [31:0] ss_s2, m8_s2, m8_s3, m9_s3;
	logic [18:0] t_s1, t_s2, t_s3, temp_s4;
	logic        z_s1, z_s2, z_s3, zero_s4;
	logic [31:0] sh1, corr;

	assign sh1 = {3'd0, p_s1[31:3]};
	assign corr = bsc_pkg::asr(bsc_pkg::asr(m9_s3, 12) + bsc_pkg::asr(m8_s3, 13) + coef.p7, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= in_side.hi ? {quo[30:0], 1'b0} : quo;
			t_s1 <= in_side.temp;
			z_s1 <= in_side.zero;
			ss_s2 <= bsc_pkg::mul32(sh1, sh1);
			m8_s2 <= bsc_pkg::mul32({2'd0, p_s1[31:2]}, coef.p8);
			p_s2 <= p_s1;
			t_s2 <= t_s1;
			z_s2 <= z_s1;
			m9_s3 <= bsc_pkg::mul32(coef.p9, {13'd0, ss_s2[31:13]});
			m8_s3 <= m8_s2;
			p_s3 <= p_s2;
			t_s3 <= t_s2;
			z_s3 <= z_s2;
			press_s4 <= z_s3 ? 32'd0 : p_s3 + corr;
			temp_s4 <= t_s3;
			zero_s4 <= z_s3;
		end
	end

	assign out_valid = v_q[3];
	assign temp = temp_s4;
	assign press = press_s4;
	assign zero = zero_s4;

endmodule

// File: rtl/barometric_sensor_compensation.sv
// top level: calibration registers and the compensation pipeline
`timescale 1ns / 1ps
// channel  dir  handshake              payload
// s_axis   in   s_tvalid / s_tready   s_tdata: adc_temp, adc_press
// m_axis   out  m_tvalid / m_tready   m_tdata: temperature_centi, pressure_pa; m_tuser: scale_zero
// cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// 10 front stages, 32 divider stages (one quotient bit each), 4 correction stages;
// one word accepted per cycle while the output is not stalled
// the whole pipeline advances together; it freezes while the last stage holds an untaken word
// reset clears the valid bits and the calibration registers; cfg is always ready
module barometric_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // adc_temp [19:0], adc_press [39:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // temperature_centi [18:0], pressure_pa [50:19], zeros
	output logic [0:0]  m_tuser,   // scale_zero [0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [47:0] tcal_q;
	logic [63:0] pca_q, pcb_q;
	logic [15:0] pcc_q;
	bsc_pkg::coef_t coef;

	logic en;
	logic f_valid, d_valid;
	logic [31:0] f_num, f_den, d_quo;
	bsc_pkg::side_t f_side, d_side;
	logic [18:0] temp;
	logic [31:0] press;
	logic zero;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			pca_q <= '0;
			pcb_q <= '0;
			pcc_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsc_pkg::RegTemp:   tcal_q <= cfg_data[47:0];
				bsc_pkg::RegPressA: pca_q <= cfg_data;
				bsc_pkg::RegPressB: pcb_q <= cfg_data;
				bsc_pkg::RegPressC: pcc_q <= cfg_data[15:0];
			endcase
		end
	end

	// coefficient unpacking
	assign coef.t1 = {16'd0, tcal_q[15:0]};
	assign coef.t2 = bsc_pkg::sx16(tcal_q[31:16]);
	assign coef.t3 = bsc_pkg::sx16(tcal_q[47:32]);
	assign coef.p1 = {16'd0, pca_q[15:0]};
	assign coef.p2 = bsc_pkg::sx16(pca_q[31:16]);
	assign coef.p3 = bsc_pkg::sx16(pca_q[47:32]);
	assign coef.p4 = bsc_pkg::sx16(pca_q[63:48]);
	assign coef.p5 = bsc_pkg::sx16(pcb_q[15:0]);
	assign coef.p6 = bsc_pkg::sx16(pcb_q[31:16]);
	assign coef.p7 = bsc_pkg::sx16(pcb_q[47:32]);
	assign coef.p8 = bsc_pkg::sx16(pcb_q[63:48]);
	assign coef.p9 = bsc_pkg::sx16(pcc_q);

	// global advance: move unless a finished word waits at the output
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	bsc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid), .adc_t(s_tdata[19:0]), .adc_p(s_tdata[39:20]),
		.coef(coef), .out_valid(f_valid), .dividend(f_num), .divisor(f_den),
		.side(f_side)
	);

	bsc_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_valid), .num(f_num), .den(f_den), .in_side(f_side),
		.out_valid(d_valid), .quo(d_quo), .out_side(d_side)
	);

	bsc_post u_post (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(d_valid), .quo(d_quo), .in_side(d_side), .coef(coef),
		.out_valid(m_tvalid), .temp(temp), .press(press), .zero(zero)
	);

	assign m_tdata = {5'd0, press, temp};
	assign m_tuser = zero;

endmodule
